### design/sfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_pkg
// shared types and constants for the slot free-list allocator
// ----------------------------------------------------------------------------
package sfl_pkg;

   localparam int POOL_SIZE = 64;
   localparam int ADDR_W    = $clog2(POOL_SIZE);
   localparam int LINK_W    = $clog2(POOL_SIZE + 1);
   localparam int INDEX_W   = 7;
   localparam int GRANT_W   = 6;
   localparam int STATUS_W  = 2;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SIZE);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_OUT_OF_SLOTS = 2'd1,
      ST_INVALID      = 2'd2
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // one word of the slot store
   typedef struct packed {
      logic              busy;
      logic [LINK_W-1:0] link;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### design/sfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module sfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/slot_free_list_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_free_list_allocator_core
// free-list allocator for a fixed pool of slots held in one slot store
// ----------------------------------------------------------------------------
// usage:
//   request beat: drive req_type and req_slot_index and raise start; the beat
//   is taken at a rising edge where start is high and busy is low.
//   allocate (req_type 0) pops the head slot; free (req_type 1) pushes
//   req_slot_index back after checking range and busy state.
//   response beat: rsp_valid is high for exactly one cycle with rsp_status
//   and rsp_granted_slot; busy rises at the request edge and rsp_valid is
//   registered from busy. the receiver cannot hold responses off.
//   requests: no new request is taken while busy is high. the request edge
//   starts a synchronous read of the slot store entry; while busy is high,
//   the core modifies the entry, writes it back and moves the list head.
//   reset: synchronous, active high. after reset the free list is the chain
//   0,1,2,... with no slot in use; per-entry valid flags stand in for the
//   store contents until an entry is first written, so no clearing pass runs.
// ----------------------------------------------------------------------------
module slot_free_list_allocator_core
   import sfl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  logic [INDEX_W-1:0]  req_slot_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [GRANT_W-1:0]  rsp_granted_slot
);

   logic                busy_ff;
   op_type              op_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic                out_of_range_ff;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [POOL_SIZE-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff, rsp_status_in;
   logic [GRANT_W-1:0]  rsp_granted_ff, rsp_granted_in;

   logic                accept;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   entry_type           entry;
   logic                wr_en;
   entry_type           wr_entry;

   assign accept  = start && !busy_ff;
   assign rd_addr = (req_type == OP_FREE) ? req_slot_index[ADDR_W-1:0]
                                          : head_ff[ADDR_W-1:0];

   sfl_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(POOL_SIZE)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr_ff),
      .wr_data(wr_entry),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // untouched entries read as their reset value: free, linked to the next
   always_comb begin
      if (valid_ff[addr_ff]) begin
         entry = entry_type'(rd_data);
      end else begin
         entry.busy = 1'b0;
         entry.link = LINK_W'(addr_ff) + LINK_W'(1);
      end
   end

   always_comb begin
      wr_en          = 1'b0;
      wr_entry       = '{busy: 1'b0, link: head_ff};
      head_in        = head_ff;
      valid_in       = valid_ff;
      rsp_status_in  = ST_OK;
      rsp_granted_in = '0;
      if (busy_ff) begin
         case (op_ff)
            OP_ALLOC: begin
               if (head_ff == NULL_LINK) begin
                  rsp_status_in = ST_OUT_OF_SLOTS;
               end else begin
                  wr_en          = 1'b1;
                  wr_entry       = '{busy: 1'b1, link: NULL_LINK};
                  head_in        = entry.link;
                  rsp_granted_in = GRANT_W'(addr_ff);
               end
            end
            OP_FREE: begin
               if (out_of_range_ff || !entry.busy) begin
                  rsp_status_in = ST_INVALID;
               end else begin
                  wr_en    = 1'b1;
                  wr_entry = '{busy: 1'b0, link: head_ff};
                  head_in  = LINK_W'(addr_ff);
               end
            end
            default: begin
               rsp_status_in = ST_INVALID;
            end
         endcase
         if (wr_en) begin
            valid_in[addr_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         head_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= accept;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff           <= op_type'(req_type);
         addr_ff         <= rd_addr;
         out_of_range_ff <= (req_type == OP_FREE) &&
                            (req_slot_index >= INDEX_W'(POOL_SIZE));
      end
      if (busy_ff) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_granted_ff <= rsp_granted_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;

   a_single_beat_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held for more than one cycle");

   a_rsp_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy_ff))
      else $error("response beat without a request in progress");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NULL_LINK)
      else $error("list head beyond the null link");

   a_empty_means_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_OUT_OF_SLOTS) |-> head_ff == NULL_LINK)
      else $error("out-of-slots reported with a non-empty list");

endmodule
